// ----- hdl/tsfab_pkg.sv -----
`default_nettype none
package tsfab_pkg;

    // request codes
    localparam logic [1:0] REQ_DRAW  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_RED    = 3'd0;
    localparam logic [2:0] CFG_GREEN  = 3'd1;
    localparam logic [2:0] CFG_BLUE   = 3'd2;
    localparam logic [2:0] CFG_ALPHA  = 3'd3;
    localparam logic [2:0] CFG_CLIP_W = 3'd4;
    localparam logic [2:0] CFG_CLIP_H = 3'd5;

    // fixed point and datapath widths
    localparam int FRAC = 16;   // 30.16 edge positions
    localparam int VW   = 29;   // slope, signed
    localparam int DW   = 28;   // slope magnitude bits
    localparam int XW   = 46;   // edge position, signed
    localparam int YW   = 14;   // row and row delta, signed
    localparam int CW   = 13;   // column and clip, unsigned

    localparam logic [7:0] ALPHA_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [11:0] ax;
        logic signed [11:0] ay;
        logic signed [11:0] bx;
        logic signed [11:0] by;
        logic signed [11:0] cx;
        logic signed [11:0] cy;
        logic [7:0]         pix_x;
        logic [7:0]         pix_y;
        logic [23:0]        pix_data;
    } cmd_t;

    typedef struct packed {
        logic [23:0] read_data;
        logic        drew;
    } rsp_t;

endpackage
`default_nettype wire

// ----- hdl/tsfab_ram.sv -----
`default_nettype none
module tsfab_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- hdl/tsfab_div.sv -----
`default_nettype none
module tsfab_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic signed [tsfab_pkg::VW-1:0]  num,
    input  wire logic [11:0]                      den,
    output logic                                  done,
    output logic signed [tsfab_pkg::VW-1:0]       quo
);

    localparam int N = tsfab_pkg::DW;

    logic [N-1:0]           mag_reg;
    logic [11:0]            rem_reg;
    logic [11:0]            den_reg;
    logic                   neg_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [$clog2(N)-1:0]   cnt_reg;
    logic [12:0]            trial;
    logic                   fits;
    logic [N-1:0]           num_abs;

    // one restoring step: bring down the next dividend bit
    always_comb
    begin
        trial   = {rem_reg, mag_reg[N-1]};
        fits    = trial >= {1'b0, den_reg};
        num_abs = num[tsfab_pkg::VW-1] ? N'(-num) : N'(num);
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(N))'(N - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // dividend shifts out, quotient shifts in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= num_abs;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[tsfab_pkg::VW-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? 12'(trial - {1'b0, den_reg}) : trial[11:0];
            mag_reg <= {mag_reg[N-2:0], fits};
        end
    end

    // truncation toward zero
    assign quo  = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    assign done = done_reg;

endmodule
`default_nettype wire

// ----- hdl/tsfab_blend.sv -----
`default_nettype none
module tsfab_blend (
    input  wire logic [23:0] color,
    input  wire logic [7:0]  alpha,
    input  wire logic [23:0] dest,
    output logic      [23:0] result
);

    // exact floor(x/255) for 16-bit x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = 17'(x) + 17'(x[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    logic [7:0] inv_alpha;

    assign inv_alpha = tsfab_pkg::ALPHA_MAX - alpha;

    // per channel source over destination
    for (genvar ch = 0; ch < 3; ch++)
    begin : g_ch
        logic [15:0] src_p;
        logic [15:0] dst_p;
        assign src_p = color[ch*8 +: 8] * alpha;
        assign dst_p = dest[ch*8 +: 8] * inv_alpha;
        assign result[ch*8 +: 8] = div255(src_p) + div255(dst_p);
    end

endmodule
`default_nettype wire

// ----- hdl/triangle_span_fill_alpha_blend_unit.sv -----
`default_nettype none
// Triangle span fill with alpha blend over an on-chip frame store.
// Requests enter on cmd (cmd_valid / cmd_stall), one result leaves on rsp
// (rsp_valid / rsp_stall) per request. Configuration goes through cfg_valid /
// cfg_ready / cfg_index / cfg_data; cfg_ready is always high.
// One request is worked at a time; cmd_stall is high from acceptance until the
// result is loaded into the output register. A waiting result does not block
// the next request from being taken.
// A draw runs setup first (three 28-step slope divisions on one shared
// divider and one pass of the shared multiplier for the long edge at the
// middle row), then works through each visible row and each covered pixel,
// reading then writing each pixel over the single frame store port pair.
// While rsp is stalled the result stays in its register; a new result then
// holds the block in its final state until the transfer goes through.
// Reset clears control state and sets the configuration registers to their
// defaults (opaque black, full window). The frame store is not cleared:
// software writes a pixel before reading or drawing over it.
module triangle_span_fill_alpha_blend_unit #(
    parameter int FB_WIDTH  = 256,
    parameter int FB_HEIGHT = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire tsfab_pkg::cmd_t   cmd,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output tsfab_pkg::rsp_t        rsp,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [8:0]        cfg_data
);

    localparam int AW = $clog2(FB_WIDTH * FB_HEIGHT);
    localparam int VW = tsfab_pkg::VW;
    localparam int XW = tsfab_pkg::XW;
    localparam int YW = tsfab_pkg::YW;
    localparam int CW = tsfab_pkg::CW;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECODE   = 4'd1;
    localparam logic [3:0] ST_RDWAIT   = 4'd2;
    localparam logic [3:0] ST_DIVGO    = 4'd3;
    localparam logic [3:0] ST_DIVWAIT  = 4'd4;
    localparam logic [3:0] ST_MID      = 4'd5;
    localparam logic [3:0] ST_MID2     = 4'd6;
    localparam logic [3:0] ST_SEGSTART = 4'd7;
    localparam logic [3:0] ST_ROWL     = 4'd8;
    localparam logic [3:0] ST_ROWR     = 4'd9;
    localparam logic [3:0] ST_ROWE     = 4'd10;
    localparam logic [3:0] ST_PIXRD    = 4'd11;
    localparam logic [3:0] ST_PIXWR    = 4'd12;
    localparam logic [3:0] ST_ROWNEXT  = 4'd13;
    localparam logic [3:0] ST_DONE     = 4'd14;

    // 12.0 vertex to 30.16 edge position
    function automatic logic signed [XW-1:0] to_fix(input logic signed [11:0] v);
        return XW'($signed({v, 16'h0000}));
    endfunction

    // floor of 30.16 position, clamped to columns 0 .. clip
    function automatic logic [CW-1:0] clamp_col(input logic signed [XW-1:0] s,
                                                input logic [CW-1:0] clip);
        logic signed [XW-1:0] fl;
        fl = s >>> tsfab_pkg::FRAC;
        if (s < 0)
        begin
            return '0;
        end
        if (fl > $signed(XW'(clip)))
        begin
            return clip;
        end
        return CW'(fl);
    endfunction

    // configuration registers
    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg;
    logic [8:0] clip_w_reg, clip_h_reg;

    // sequencer and request registers
    logic [3:0]  state_reg, state_next;
    logic [1:0]  req_reg, req_next;
    logic [7:0]  pix_x_reg, pix_x_next;
    logic [7:0]  pix_y_reg, pix_y_next;
    logic [23:0] pix_data_reg, pix_data_next;
    logic signed [11:0] sx0_reg, sy0_reg, sx1_reg, sy1_reg, sx2_reg, sy2_reg;
    logic signed [11:0] sx0_next, sy0_next, sx1_next, sy1_next, sx2_next, sy2_next;
    logic [1:0]  div_idx_reg, div_idx_next;
    logic signed [VW-1:0] v01_reg, v02_reg, v12_reg;
    logic signed [VW-1:0] v01_next, v02_next, v12_next;
    logic signed [XW-1:0] prod_reg, prod_next;
    logic signed [XW-1:0] mid_reg, mid_next;
    logic        seg_reg, seg_next;
    logic signed [YW-1:0] y_reg, y_next;
    logic signed [YW-1:0] yend_reg, yend_next;
    logic [CW-1:0] x_reg, x_next;
    logic [CW-1:0] xend_reg, xend_next;
    logic [23:0] res_data_reg, res_data_next;
    logic        res_drew_reg, res_drew_next;
    logic        rsp_valid_reg, rsp_valid_next;
    tsfab_pkg::rsp_t rsp_reg, rsp_next;

    // frame store and shared units
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [23:0]   ram_wdata, ram_rdata, blend_out;
    logic          div_start, div_done;
    logic signed [VW-1:0] div_num, div_quo;
    logic [11:0]   div_den;
    logic signed [VW-1:0] mul_a;
    logic signed [YW-1:0] mul_b;
    logic signed [VW+YW-1:0] mul_p;

    // sort, window and span helpers
    logic signed [11:0] ox0, oy0, ox1, oy1, ox2, oy2;
    logic [CW-1:0] clipr, clipb;
    logic [AW-1:0] pix_addr, frame_addr;
    logic          pix_in;
    logic          flat_top, flat_bot, degen, two_seg;
    logic signed [VW-1:0] seg_vl, seg_vr;
    logic signed [XW-1:0] seg_xl, seg_xr;
    logic signed [YW-1:0] seg_ys, seg_ye, seg_y0, seg_y1, clipb_s, dy;
    logic signed [12:0] ddx;
    logic signed [12:0] ddy;
    logic [CW-1:0] col;

    assign cfg_ready = 1'b1;
    assign cmd_stall = state_reg != ST_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg    <= 8'd0;
            green_reg  <= 8'd0;
            blue_reg   <= 8'd0;
            alpha_reg  <= tsfab_pkg::ALPHA_MAX;
            clip_w_reg <= 9'd256;
            clip_h_reg <= 9'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tsfab_pkg::CFG_RED:    red_reg    <= cfg_data[7:0];
                tsfab_pkg::CFG_GREEN:  green_reg  <= cfg_data[7:0];
                tsfab_pkg::CFG_BLUE:   blue_reg   <= cfg_data[7:0];
                tsfab_pkg::CFG_ALPHA:  alpha_reg  <= cfg_data[7:0];
                tsfab_pkg::CFG_CLIP_W: clip_w_reg <= cfg_data;
                tsfab_pkg::CFG_CLIP_H: clip_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // vertex sort by y, ties kept in request order
    always_comb
    begin
        if (cmd.ay <= cmd.by && cmd.ay <= cmd.cy)
        begin
            ox0 = cmd.ax; oy0 = cmd.ay;
            if (cmd.by <= cmd.cy)
            begin
                ox1 = cmd.bx; oy1 = cmd.by; ox2 = cmd.cx; oy2 = cmd.cy;
            end
            else
            begin
                ox1 = cmd.cx; oy1 = cmd.cy; ox2 = cmd.bx; oy2 = cmd.by;
            end
        end
        else if (cmd.by <= cmd.ay && cmd.by <= cmd.cy)
        begin
            ox0 = cmd.bx; oy0 = cmd.by;
            if (cmd.ay <= cmd.cy)
            begin
                ox1 = cmd.ax; oy1 = cmd.ay; ox2 = cmd.cx; oy2 = cmd.cy;
            end
            else
            begin
                ox1 = cmd.cx; oy1 = cmd.cy; ox2 = cmd.ax; oy2 = cmd.ay;
            end
        end
        else
        begin
            ox0 = cmd.cx; oy0 = cmd.cy;
            if (cmd.ay <= cmd.by)
            begin
                ox1 = cmd.ax; oy1 = cmd.ay; ox2 = cmd.bx; oy2 = cmd.by;
            end
            else
            begin
                ox1 = cmd.bx; oy1 = cmd.by; ox2 = cmd.ax; oy2 = cmd.ay;
            end
        end
    end

    // window and addresses
    always_comb
    begin
        clipr = (32'(clip_w_reg) > FB_WIDTH)  ? CW'(FB_WIDTH)  : CW'(clip_w_reg);
        clipb = (32'(clip_h_reg) > FB_HEIGHT) ? CW'(FB_HEIGHT) : CW'(clip_h_reg);
        clipb_s = $signed({1'b0, clipb});
        pix_in = (32'(pix_x_reg) < FB_WIDTH) && (32'(pix_y_reg) < FB_HEIGHT);
        pix_addr   = AW'(32'(pix_y_reg) * FB_WIDTH + 32'(pix_x_reg));
        frame_addr = AW'(32'(y_reg[11:0]) * FB_WIDTH + 32'(x_reg));
    end

    // edge selection for the current segment
    always_comb
    begin
        flat_top = sy0_reg == sy1_reg;
        flat_bot = sy1_reg == sy2_reg;
        two_seg  = !flat_top && !flat_bot;
        degen    = (sy0_reg == sy2_reg)
                || (flat_top && sx0_reg == sx1_reg)
                || (!flat_top && flat_bot && sx1_reg == sx2_reg)
                || (two_seg && v01_reg == v02_reg);
        seg_ys = YW'(sy0_reg);
        seg_ye = YW'(sy1_reg);
        seg_xl = to_fix(sx0_reg);
        seg_xr = to_fix(sx0_reg);
        seg_vl = v01_reg;
        seg_vr = v02_reg;
        if (flat_top)
        begin
            // flat top: one segment between the two upper vertices
            seg_ye = YW'(sy2_reg);
            if (sx0_reg < sx1_reg)
            begin
                seg_vl = v02_reg; seg_vr = v12_reg;
                seg_xl = to_fix(sx0_reg); seg_xr = to_fix(sx1_reg);
            end
            else
            begin
                seg_vl = v12_reg; seg_vr = v02_reg;
                seg_xl = to_fix(sx1_reg); seg_xr = to_fix(sx0_reg);
            end
        end
        else if (flat_bot)
        begin
            if (!(sx1_reg < sx2_reg))
            begin
                seg_vl = v02_reg; seg_vr = v01_reg;
            end
        end
        else if (!seg_reg)
        begin
            // upper half
            if (!(v01_reg < v02_reg))
            begin
                seg_vl = v02_reg; seg_vr = v01_reg;
            end
        end
        else
        begin
            // lower half, long edge continues from the middle row
            seg_ys = YW'(sy1_reg);
            seg_ye = YW'(sy2_reg);
            if (v01_reg < v02_reg)
            begin
                seg_vl = v12_reg; seg_vr = v02_reg;
                seg_xl = to_fix(sx1_reg); seg_xr = mid_reg;
            end
            else
            begin
                seg_vl = v02_reg; seg_vr = v12_reg;
                seg_xl = mid_reg; seg_xr = to_fix(sx1_reg);
            end
        end
        seg_y0 = (seg_ys < 0) ? '0 : seg_ys;
        seg_y1 = (seg_ye < clipb_s) ? seg_ye : clipb_s;
        dy     = y_reg - seg_ys;
    end

    // divider operands by slope index
    always_comb
    begin
        case (div_idx_reg)
            2'd0:
            begin
                ddx = 13'(sx1_reg) - 13'(sx0_reg);
                ddy = 13'(sy1_reg) - 13'(sy0_reg);
            end
            2'd1:
            begin
                ddx = 13'(sx2_reg) - 13'(sx0_reg);
                ddy = 13'(sy2_reg) - 13'(sy0_reg);
            end
            default:
            begin
                ddx = 13'(sx2_reg) - 13'(sx1_reg);
                ddy = 13'(sy2_reg) - 13'(sy1_reg);
            end
        endcase
        div_num = $signed({ddx, 16'h0000});
        div_den = ddy[11:0];
    end

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            ST_MID:
            begin
                mul_a = v02_reg;
                mul_b = YW'(13'(sy1_reg) - 13'(sy0_reg));
            end
            ST_ROWR:
            begin
                mul_a = seg_vr;
                mul_b = dy;
            end
            default:
            begin
                mul_a = seg_vl;
                mul_b = dy;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        pix_x_next    = pix_x_reg;
        pix_y_next    = pix_y_reg;
        pix_data_next = pix_data_reg;
        sx0_next = sx0_reg; sy0_next = sy0_reg;
        sx1_next = sx1_reg; sy1_next = sy1_reg;
        sx2_next = sx2_reg; sy2_next = sy2_reg;
        div_idx_next  = div_idx_reg;
        v01_next = v01_reg; v02_next = v02_reg; v12_next = v12_reg;
        prod_next     = XW'(mul_p);
        mid_next      = mid_reg;
        seg_next      = seg_reg;
        y_next        = y_reg;
        yend_next     = yend_reg;
        x_next        = x_reg;
        xend_next     = xend_reg;
        res_data_next = res_data_reg;
        res_drew_next = res_drew_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next      = rsp_reg;
        ram_we        = 1'b0;
        ram_waddr     = frame_addr;
        ram_wdata     = blend_out;
        ram_raddr     = frame_addr;
        div_start     = 1'b0;
        col           = clamp_col(seg_xl + prod_reg, clipr);

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    req_next      = cmd.req_type;
                    pix_x_next    = cmd.pix_x;
                    pix_y_next    = cmd.pix_y;
                    pix_data_next = cmd.pix_data;
                    sx0_next = ox0; sy0_next = oy0;
                    sx1_next = ox1; sy1_next = oy1;
                    sx2_next = ox2; sy2_next = oy2;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                res_data_next = '0;
                res_drew_next = 1'b0;
                div_idx_next  = 2'd0;
                seg_next      = 1'b0;
                ram_waddr     = pix_addr;
                ram_wdata     = pix_data_reg;
                ram_raddr     = pix_addr;
                case (req_reg)
                    tsfab_pkg::REQ_DRAW:
                    begin
                        state_next = (sy0_reg == sy2_reg) ? ST_DONE : ST_DIVGO;
                    end
                    tsfab_pkg::REQ_WRITE:
                    begin
                        ram_we     = pix_in;
                        state_next = ST_DONE;
                    end
                    tsfab_pkg::REQ_READ:
                    begin
                        state_next = ST_RDWAIT;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_RDWAIT:
            begin
                res_data_next = pix_in ? ram_rdata : '0;
                state_next    = ST_DONE;
            end
            ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT:
            begin
                if (div_done)
                begin
                    case (div_idx_reg)
                        2'd0:    v01_next = div_quo;
                        2'd1:    v02_next = div_quo;
                        default: v12_next = div_quo;
                    endcase
                    div_idx_next = div_idx_reg + 2'd1;
                    state_next   = (div_idx_reg == 2'd2) ? ST_MID : ST_DIVGO;
                end
            end
            ST_MID:
            begin
                state_next = ST_MID2;
            end
            ST_MID2:
            begin
                mid_next   = to_fix(sx0_reg) + prod_reg;
                state_next = degen ? ST_DONE : ST_SEGSTART;
            end
            ST_SEGSTART:
            begin
                y_next    = seg_y0;
                yend_next = seg_y1;
                if (seg_y0 < seg_y1)
                begin
                    state_next = ST_ROWL;
                end
                else if (!seg_reg && two_seg)
                begin
                    seg_next = 1'b1;
                end
                else
                begin
                    res_drew_next = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_ROWL:
            begin
                state_next = ST_ROWR;
            end
            ST_ROWR:
            begin
                x_next     = col;
                state_next = ST_ROWE;
            end
            ST_ROWE:
            begin
                xend_next  = clamp_col(seg_xr + prod_reg, clipr);
                state_next = (x_reg < clamp_col(seg_xr + prod_reg, clipr)) ?
                             ST_PIXRD : ST_ROWNEXT;
            end
            ST_PIXRD:
            begin
                state_next = ST_PIXWR;
            end
            ST_PIXWR:
            begin
                ram_we     = 1'b1;
                x_next     = x_reg + 1'b1;
                state_next = ((x_reg + 1'b1) < xend_reg) ? ST_PIXRD : ST_ROWNEXT;
            end
            ST_ROWNEXT:
            begin
                y_next = y_reg + 1'b1;
                if ((y_reg + 1'b1) < yend_reg)
                begin
                    state_next = ST_ROWL;
                end
                else if (!seg_reg && two_seg)
                begin
                    seg_next   = 1'b1;
                    state_next = ST_SEGSTART;
                end
                else
                begin
                    res_drew_next = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.read_data = res_data_reg;
                    rsp_next.drew      = res_drew_reg;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            div_idx_reg   <= '0;
            seg_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            div_idx_reg   <= div_idx_next;
            seg_reg       <= seg_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pix_x_reg    <= pix_x_next;
        pix_y_reg    <= pix_y_next;
        pix_data_reg <= pix_data_next;
        sx0_reg <= sx0_next; sy0_reg <= sy0_next;
        sx1_reg <= sx1_next; sy1_reg <= sy1_next;
        sx2_reg <= sx2_next; sy2_reg <= sy2_next;
        v01_reg <= v01_next; v02_reg <= v02_next; v12_reg <= v12_next;
        prod_reg     <= prod_next;
        mid_reg      <= mid_next;
        y_reg        <= y_next;
        yend_reg     <= yend_next;
        x_reg        <= x_next;
        xend_reg     <= xend_next;
        res_data_reg <= res_data_next;
        res_drew_reg <= res_drew_next;
        rsp_reg      <= rsp_next;
    end

    tsfab_ram #(
        .WIDTH (24),
        .DEPTH (FB_WIDTH * FB_HEIGHT)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tsfab_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    tsfab_blend u_blend (
        .color  ({red_reg, green_reg, blue_reg}),
        .alpha  (alpha_reg),
        .dest   (ram_rdata),
        .result (blend_out)
    );

    // frame store is written only by a pixel write request or a blend step
    a_we_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_PIXWR || state_reg == ST_DECODE))
        else $error("frame store write outside write or blend step");

    // blend step always lands inside the span
    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PIXWR |-> x_reg < xend_reg)
        else $error("blend step beyond span end");

    // divider finishes only while the sequencer waits for it
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVWAIT)
        else $error("divider result while not waiting");

    // pixel rows are never above the window
    a_row: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PIXRD |-> !y_reg[YW-1])
        else $error("negative row in pixel loop");

    // a result enters the output register only from the final state
    a_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg) == ST_DONE)
        else $error("result loaded outside final state");

endmodule
`default_nettype wire
